/* design/dle_etx_frame_deframer_unit_assert.svh */
// Assertion macros for the DLE/ETX deframer.
`ifndef DLE_ETX_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define DLE_ETX_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DLEF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlef: implication failed");
`define DLEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlef: next-cycle check failed");
`else
`define DLEF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLEF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/dlef_pkg.sv */
// Shared types, codes and the fixed-length table of the deframer.
package dlef_pkg;

    localparam logic [7:0] CH_DLE = 8'h10;
    localparam logic [7:0] CH_ETX = 8'h03;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    localparam logic [1:0] LCHK_NONE     = 2'd0;
    localparam logic [1:0] LCHK_MATCH    = 2'd1;
    localparam logic [1:0] LCHK_MISMATCH = 2'd2;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        first;
        logic [63:0] start_time;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] fixed_len_of(input logic [7:0] id);
        logic [7:0] len;
        case (id)
            8'h41:   len = 8'd11;
            8'h4A:   len = 8'd21;
            8'h84:   len = 8'd37;
            8'h46:   len = 8'd3;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

/* design/dlef_in_if.sv */
// Receive byte channel: byte and arrival timestamp.
interface dlef_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [63:0] arrival_time;

    modport source (output valid, output rx_byte, output arrival_time, input ready);
    modport sink (input valid, input rx_byte, input arrival_time, output ready);
endinterface

/* design/dlef_out_if.sv */
// Result channel: data bytes and frame end or abort reports.
interface dlef_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        first;
    logic [7:0]  frame_length;
    logic [7:0]  message_id;
    logic [1:0]  length_check;
    logic [63:0] start_time;

    modport source (
        output valid, output kind, output data, output first, output frame_length,
        output message_id, output length_check, output start_time, input ready
    );
    modport sink (
        input valid, input kind, input data, input first, input frame_length,
        input message_id, input length_check, input start_time, output ready
    );
endinterface

/* design/dlef_front.sv */
// Front end: byte parser that classifies received bytes and turns frame bytes into commands.
module dlef_front (
    input  logic                 clk,
    input  logic                 rst_n,
    dlef_in_if.sink              rx,
    input  dlef_pkg::q_status_t  q_status,
    output logic                 push,
    output dlef_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_OPEN_DLE,
        ST_BODY,
        ST_BODY_DLE
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [63:0] start_reg;
    logic [63:0] start_next;
    logic        xfer;

    assign rx.ready = !q_status.full;
    assign xfer     = rx.valid && rx.ready;

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        push           = 1'b0;
        cmd.kind       = dlef_pkg::KIND_DATA;
        cmd.data       = rx.rx_byte;
        cmd.first      = 1'b0;
        cmd.start_time = start_reg;
        if (xfer)
        begin
            case (state_reg)
                ST_HUNT:
                begin
                    if (rx.rx_byte == dlef_pkg::CH_DLE)
                    begin
                        state_next = ST_OPEN_DLE;
                        start_next = rx.arrival_time;
                    end
                end
                ST_OPEN_DLE:
                begin
                    if (!(rx.rx_byte inside {dlef_pkg::CH_DLE, dlef_pkg::CH_ETX}))
                    begin
                        state_next = ST_BODY;
                        push       = 1'b1;
                        cmd.first  = 1'b1;
                    end
                end
                ST_BODY:
                begin
                    if (rx.rx_byte == dlef_pkg::CH_DLE)
                        state_next = ST_BODY_DLE;
                    else
                        push = 1'b1;
                end
                ST_BODY_DLE:
                begin
                    push = 1'b1;
                    if (rx.rx_byte == dlef_pkg::CH_DLE)
                        state_next = ST_BODY;
                    else if (rx.rx_byte == dlef_pkg::CH_ETX)
                    begin
                        state_next = ST_HUNT;
                        cmd.kind   = dlef_pkg::KIND_END;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                        cmd.kind   = dlef_pkg::KIND_ABORT;
                    end
                end
                default:
                    state_next = ST_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

endmodule

/* design/dlef_queue.sv */
// Two-entry command queue between parser and result stage.
module dlef_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dlef_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output dlef_pkg::cmd_t       head_cmd,
    output dlef_pkg::q_status_t  status
);

    dlef_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* design/dlef_back.sv */
// Back end: frame length and ID tracking, length check and result register.
module dlef_back #(
    parameter int MAX_FRAME_LEN = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlef_pkg::cmd_t       cmd,
    input  dlef_pkg::q_status_t  q_status,
    output logic                 pop,
    dlef_out_if.source           result
);

    localparam int CW = $clog2(MAX_FRAME_LEN + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    id_reg;
    logic [7:0]    id_next;
    logic [15:0]   count_ext;
    logic [15:0]   fl_ext;
    logic          valid_reg;
    logic [1:0]    kind_reg;
    logic [7:0]    data_reg;
    logic [7:0]    data_next;
    logic          first_reg;
    logic          first_next;
    logic [7:0]    flen_reg;
    logic [7:0]    flen_next;
    logic [7:0]    mid_reg;
    logic [7:0]    mid_next;
    logic [1:0]    lchk_reg;
    logic [1:0]    lchk_next;
    logic [63:0]   stime_reg;
    logic [63:0]   stime_next;
    logic [1:0]    lchk_calc;
    logic [7:0]    flen_sat;

    assign pop       = !q_status.empty && (!valid_reg || result.ready);
    assign count_ext = 16'(count_reg);
    assign fl_ext    = 16'(dlef_pkg::fixed_len_of(id_reg));
    assign flen_sat  = (count_ext > 16'd255) ? 8'hFF : count_ext[7:0];

    always_comb
    begin
        if (fl_ext == 16'd0)
            lchk_calc = dlef_pkg::LCHK_NONE;
        else if (fl_ext == count_ext)
            lchk_calc = dlef_pkg::LCHK_MATCH;
        else
            lchk_calc = dlef_pkg::LCHK_MISMATCH;
    end

    always_comb
    begin
        count_next = count_reg;
        id_next    = id_reg;
        if (pop && cmd.kind == dlef_pkg::KIND_DATA)
        begin
            if (cmd.first)
            begin
                count_next = CW'(1);
                id_next    = cmd.data;
            end
            else if (count_reg < CW'(MAX_FRAME_LEN))
                count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        data_next  = '0;
        first_next = 1'b0;
        flen_next  = '0;
        mid_next   = '0;
        lchk_next  = dlef_pkg::LCHK_NONE;
        stime_next = '0;
        case (cmd.kind)
            dlef_pkg::KIND_DATA:
            begin
                data_next  = cmd.data;
                first_next = cmd.first;
            end
            dlef_pkg::KIND_END:
            begin
                flen_next  = flen_sat;
                mid_next   = id_reg;
                lchk_next  = lchk_calc;
                stime_next = cmd.start_time;
            end
            default:
            begin
                data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            id_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            id_reg    <= id_next;
            if (pop)
                valid_reg <= 1'b1;
            else if (result.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= cmd.kind;
            data_reg  <= data_next;
            first_reg <= first_next;
            flen_reg  <= flen_next;
            mid_reg   <= mid_next;
            lchk_reg  <= lchk_next;
            stime_reg <= stime_next;
        end
    end

    assign result.valid        = valid_reg;
    assign result.kind         = kind_reg;
    assign result.data         = data_reg;
    assign result.first        = first_reg;
    assign result.frame_length = flen_reg;
    assign result.message_id   = mid_reg;
    assign result.length_check = lchk_reg;
    assign result.start_time   = stime_reg;

endmodule

/* design/dle_etx_frame_deframer_unit.sv */
// Top level of the DLE/ETX byte-unstuffing deframer.
// Throughput: one byte per cycle; a transfer on rx is taken whenever the queue has room.
// A byte's result is registered in a queue entry and then in the result register.
// The two-entry queue lets the parser run on while a result waits on result.ready.
// Reset (rst_n, asynchronous): parser hunts for DLE, counters, ID and start time cleared.
`include "dle_etx_frame_deframer_unit_assert.svh"

module dle_etx_frame_deframer_unit #(
    parameter int MAX_FRAME_LEN = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    dlef_in_if.sink     rx,
    dlef_out_if.source  result
);

    dlef_pkg::cmd_t      push_cmd;
    dlef_pkg::cmd_t      head_cmd;
    dlef_pkg::q_status_t q_status;
    logic                push;
    logic                pop;

    dlef_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    dlef_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    dlef_back #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

    `DLEF_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !q_status.full)
    `DLEF_ASSERT_IMP(a_pop_needs_slot, clk, rst_n, pop, (!result.valid || result.ready))
    `DLEF_ASSERT_NEXT(a_pop_gives_result, clk, rst_n, pop, result.valid)
    `DLEF_ASSERT_IMP(a_report_no_data, clk, rst_n,
        result.valid && result.kind != dlef_pkg::KIND_DATA,
        result.data == 8'd0 && result.first == 1'b0)

endmodule

/* tb/dle_etx_frame_deframer_unit_tb.sv */
// Self-checking testbench for the DLE/ETX deframer: directed rows, then random framed traffic.
`timescale 1ns / 1ps

module dle_etx_frame_deframer_unit_tb;

    localparam int FRAME_LEN_CAP  = 255;
    localparam int RANDOM_BYTES   = 1300;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum logic [1:0] {
        PS_HUNT,
        PS_OPEN_DLE,
        PS_BODY,
        PS_BODY_DLE
    } parse_state_t;

    typedef enum logic [2:0] {
        EXP_PREDICT,
        EXP_NONE,
        EXP_FIRST,
        EXP_DATA,
        EXP_END,
        EXP_ABORT
    } row_expect_t;

    typedef struct packed {
        dlef_pkg::kind_t kind;
        logic [7:0]      data;
        logic            first;
        logic [7:0]      frame_length;
        logic [7:0]      message_id;
        logic [1:0]      length_check;
        logic [63:0]     start_time;
    } frame_report_t;

    typedef struct {
        logic [7:0]  rx_byte;
        logic [63:0] arrival;
        row_expect_t how;
        logic [7:0]  value;
        logic [7:0]  id;
        logic [1:0]  check;
        logic [63:0] start;
    } stim_row_t;

    logic clk;
    logic rst_n;

    dlef_in_if  rx();
    dlef_out_if result();

    dle_etx_frame_deframer_unit #(
        .MAX_FRAME_LEN(FRAME_LEN_CAP)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .result (result)
    );

    // predictor state
    parse_state_t parse_state;
    logic [63:0]  opening_time;
    int           frame_bytes;
    logic [7:0]   frame_id;

    frame_report_t pending_reports[$];
    stim_row_t     stim_rows[$];

    int  errors;
    int  bytes_sent;
    int  data_seen;
    int  ends_seen;
    int  aborts_seen;
    int  saturated_ends;
    int  holds_done;
    int  quiet_cycles;
    bit  steady_sender;
    bit  steady_sink;
    bit  hold_request;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [7:0] known_length(input logic [7:0] id);
        logic [7:0] len;
        len = 8'd0;
        if (id == 8'h41) len = 8'd11;
        else if (id == 8'h4A) len = 8'd21;
        else if (id == 8'h84) len = 8'd37;
        else if (id == 8'h46) len = 8'd3;
        return len;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, input logic [63:0] t,
                                        output frame_report_t rep);
        bit         produced;
        logic [7:0] fixed;
        rep      = '0;
        produced = 1'b0;
        case (parse_state)
            PS_HUNT:
            begin
                if (b == dlef_pkg::CH_DLE)
                begin
                    parse_state  = PS_OPEN_DLE;
                    opening_time = t;
                end
            end
            PS_OPEN_DLE:
            begin
                if (b != dlef_pkg::CH_DLE && b != dlef_pkg::CH_ETX)
                begin
                    parse_state = PS_BODY;
                    frame_id    = b;
                    frame_bytes = 1;
                    rep.kind    = dlef_pkg::KIND_DATA;
                    rep.data    = b;
                    rep.first   = 1'b1;
                    produced    = 1'b1;
                end
            end
            PS_BODY:
            begin
                if (b == dlef_pkg::CH_DLE)
                    parse_state = PS_BODY_DLE;
                else
                begin
                    if (frame_bytes < FRAME_LEN_CAP) frame_bytes++;
                    rep.kind = dlef_pkg::KIND_DATA;
                    rep.data = b;
                    produced = 1'b1;
                end
            end
            default:
            begin
                produced = 1'b1;
                if (b == dlef_pkg::CH_DLE)
                begin
                    parse_state = PS_BODY;
                    if (frame_bytes < FRAME_LEN_CAP) frame_bytes++;
                    rep.kind = dlef_pkg::KIND_DATA;
                    rep.data = dlef_pkg::CH_DLE;
                end
                else
                begin
                    parse_state = PS_HUNT;
                    if (b == dlef_pkg::CH_ETX)
                    begin
                        fixed            = known_length(frame_id);
                        rep.kind         = dlef_pkg::KIND_END;
                        rep.frame_length = (frame_bytes > 255) ? 8'd255 : frame_bytes[7:0];
                        rep.message_id   = frame_id;
                        if (fixed == 8'd0)
                            rep.length_check = dlef_pkg::LCHK_NONE;
                        else if (fixed == frame_bytes)
                            rep.length_check = dlef_pkg::LCHK_MATCH;
                        else
                            rep.length_check = dlef_pkg::LCHK_MISMATCH;
                        rep.start_time = opening_time;
                    end
                    else
                        rep.kind = dlef_pkg::KIND_ABORT;
                end
            end
        endcase
        return produced;
    endfunction

    function automatic int gap_length(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    task automatic add_row(input logic [7:0] b, input logic [63:0] t, input row_expect_t how,
                           input logic [7:0] value, input logic [7:0] id,
                           input logic [1:0] check, input logic [63:0] start);
        stim_row_t row;
        row.rx_byte = b;
        row.arrival = t;
        row.how     = how;
        row.value   = value;
        row.id      = id;
        row.check   = check;
        row.start   = start;
        stim_rows.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [63:0] t);
        int gap;
        gap = gap_length(steady_sender);
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid        <= 1'b1;
        rx.rx_byte      <= b;
        rx.arrival_time <= t;
        @(posedge clk);
        while (!rx.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic transfer_byte(input logic [7:0] b);
        logic [63:0]   t;
        frame_report_t rep;
        t = {$urandom, $urandom};
        send_byte(b, t);
        if (deframe_byte(b, t, rep)) pending_reports.push_back(rep);
    endtask

    // body_len < 0 picks a random body; a fixed body always ends cleanly
    task automatic send_frame(input int body_len);
        int         body;
        int         r;
        logic [7:0] b;
        logic [7:0] id;
        logic [7:0] fixed;
        repeat ($urandom_range(0, 3))
        begin
            b = 8'($urandom_range(0, 255));
            if (b == dlef_pkg::CH_DLE) b = dlef_pkg::CH_ETX;
            transfer_byte(b);
        end
        transfer_byte(dlef_pkg::CH_DLE);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2))
                transfer_byte($urandom_range(0, 1) ? dlef_pkg::CH_DLE : dlef_pkg::CH_ETX);
        r = $urandom_range(0, 99);
        if (r < 15) id = 8'h41;
        else if (r < 30) id = 8'h4A;
        else if (r < 45) id = 8'h84;
        else if (r < 60) id = 8'h46;
        else
        begin
            do id = 8'($urandom_range(0, 255));
            while (id == dlef_pkg::CH_DLE || id == dlef_pkg::CH_ETX);
        end
        transfer_byte(id);
        fixed = known_length(id);
        if (body_len >= 0) body = body_len;
        else if (fixed != 8'd0 && $urandom_range(0, 9) < 7) body = fixed - 1;
        else body = $urandom_range(0, 40);
        repeat (body)
        begin
            b = ($urandom_range(0, 7) == 0) ? dlef_pkg::CH_DLE : 8'($urandom_range(0, 255));
            transfer_byte(b);
            if (b == dlef_pkg::CH_DLE) transfer_byte(dlef_pkg::CH_DLE);
        end
        r = (body_len >= 0) ? 0 : $urandom_range(0, 99);
        if (r < 80)
        begin
            transfer_byte(dlef_pkg::CH_DLE);
            transfer_byte(dlef_pkg::CH_ETX);
        end
        else if (r < 92)
        begin
            transfer_byte(dlef_pkg::CH_DLE);
            do b = 8'($urandom_range(0, 255));
            while (b == dlef_pkg::CH_DLE || b == dlef_pkg::CH_ETX);
            transfer_byte(b);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        frame_report_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual kind %0d data %0h",
                         $time, result.kind, result.data);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("kind", want.kind, result.kind);
                check_field("data", want.data, result.data);
                check_field("first", want.first, result.first);
                check_field("frame_length", want.frame_length, result.frame_length);
                check_field("message_id", want.message_id, result.message_id);
                check_field("length_check", want.length_check, result.length_check);
                check_field("start_time", want.start_time, result.start_time);
                case (want.kind)
                    dlef_pkg::KIND_DATA: data_seen++;
                    dlef_pkg::KIND_END:
                    begin
                        ends_seen++;
                        if (want.frame_length == 8'd255) saturated_ends++;
                    end
                    default: aborts_seen++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx.valid && rx.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : drive_result_ready
        int stall;
        result.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else
            begin
                stall = gap_length(steady_sink);
                if (stall > 0)
                begin
                    result.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 15) == 0) steady_sink = !steady_sink;
        end
    end

    initial
    begin : stimulus
        stim_row_t     row;
        frame_report_t rep;
        frame_report_t lit;
        bit            produced;
        int            frame_no;
        int            target;

        errors          = 0;
        bytes_sent      = 0;
        data_seen       = 0;
        ends_seen       = 0;
        aborts_seen     = 0;
        saturated_ends  = 0;
        holds_done      = 0;
        quiet_cycles    = 0;
        steady_sender   = 1'b0;
        steady_sink     = 1'b0;
        hold_request    = 1'b0;
        parse_state     = PS_HUNT;
        opening_time    = '0;
        frame_bytes     = 0;
        frame_id        = '0;
        rx.valid        = 1'b0;
        rx.rx_byte      = '0;
        rx.arrival_time = '0;
        rst_n           = 1'b0;

        // byte, time, expectation, data or length, id, length check, start time
        add_row(8'h00, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'hFF, '1, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, '1, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_ETX, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'h46, 64'h0, EXP_FIRST, 8'h46, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, '1, EXP_DATA, dlef_pkg::CH_DLE, 8'h00,
                dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'hFF, 64'h0, EXP_DATA, 8'hFF, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_ETX, 64'h0, EXP_END, 8'd3, 8'h46, dlef_pkg::LCHK_MATCH, '1);
        add_row(dlef_pkg::CH_DLE, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'h41, '1, EXP_FIRST, 8'h41, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'h00, 64'h0, EXP_DATA, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_ETX, 64'h0, EXP_END, 8'd2, 8'h41, dlef_pkg::LCHK_MISMATCH, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h8000_0000_0000_0001, EXP_NONE, 8'h00, 8'h00,
                dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'h00, 64'h0, EXP_FIRST, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h0, EXP_NONE, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'h55, 64'h0, EXP_ABORT, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h0123_4567_89AB_CDEF, EXP_PREDICT, 8'h00, 8'h00,
                dlef_pkg::LCHK_NONE, 64'h0);
        add_row(8'h22, 64'h7FFF_FFFF_FFFF_FFFE, EXP_PREDICT, 8'h00, 8'h00,
                dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_DLE, 64'h0, EXP_PREDICT, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);
        add_row(dlef_pkg::CH_ETX, '1, EXP_PREDICT, 8'h00, 8'h00, dlef_pkg::LCHK_NONE, 64'h0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            send_byte(row.rx_byte, row.arrival);
            produced = deframe_byte(row.rx_byte, row.arrival, rep);
            lit      = '0;
            case (row.how)
                EXP_PREDICT: if (produced) pending_reports.push_back(rep);
                EXP_FIRST, EXP_DATA:
                begin
                    lit.kind  = dlef_pkg::KIND_DATA;
                    lit.data  = row.value;
                    lit.first = (row.how == EXP_FIRST);
                    pending_reports.push_back(lit);
                end
                EXP_END:
                begin
                    lit.kind         = dlef_pkg::KIND_END;
                    lit.frame_length = row.value;
                    lit.message_id   = row.id;
                    lit.length_check = row.check;
                    lit.start_time   = row.start;
                    pending_reports.push_back(lit);
                end
                EXP_ABORT:
                begin
                    lit.kind = dlef_pkg::KIND_ABORT;
                    pending_reports.push_back(lit);
                end
                default: ;
            endcase
        end

        // first random frame runs gap-free into the receiver hold-off to back up the input
        hold_request = 1'b1;
        target       = bytes_sent + RANDOM_BYTES;
        frame_no     = 0;
        while (bytes_sent < target)
        begin
            steady_sender = (frame_no == 0) || ($urandom_range(0, 4) == 0);
            if (frame_no == 0)
                send_frame(60);
            else if (frame_no % 30 == 7)
                send_frame($urandom_range(255, 300));
            else
                send_frame(-1);
            frame_no++;
        end
        rx.valid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d byte transfers in %0d random frames after the directed rows.",
                 bytes_sent, frame_no);
        $display("Results: %0d data, %0d ends (%0d saturated), %0d aborts; %0d long hold-off(s).",
                 data_seen, ends_seen, saturated_ends, aborts_seen, holds_done);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/dlef_pkg.sv
design/dlef_in_if.sv
design/dlef_out_if.sv
design/dlef_front.sv
design/dlef_queue.sv
design/dlef_back.sv
design/dle_etx_frame_deframer_unit.sv
tb/dle_etx_frame_deframer_unit_tb.sv
